// ----- rtl/core/tspg_pkg.sv -----
// ----------------------------------------------------------------------------
// tspg_pkg
// Shared types and constants for the temperature servo pulse generator.
// ----------------------------------------------------------------------------
package tspg_pkg;

  // Item kinds carried on the input tuser field.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_PERIOD = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Pulse width limits in ticks and the span between them.
  localparam logic [6:0] WIDTH_MIN  = 7'd47;
  localparam logic [6:0] WIDTH_MAX  = 7'd97;
  localparam logic [5:0] WIDTH_SPAN = 6'd50;

  // Converter scale: temperature = sample * ADC_SCALE >> ADC_BITS.
  localparam int unsigned ADC_BITS  = 10;
  localparam logic [7:0]  ADC_SCALE = 8'd250;

  // Reset values of the bound registers.
  localparam logic [7:0] TMIN_RESET = 8'd0;
  localparam logic [7:0] TMAX_RESET = 8'd150;

  // Divider operand widths: numerator below 255 * 50, divisor one byte.
  localparam int unsigned NUM_W = 14;
  localparam int unsigned DEN_W = 8;

  // Configuration register indexes.
  localparam logic REG_TMIN = 1'b0;
  localparam logic REG_TMAX = 1'b1;

  // Request into the shared divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // One result item.
  typedef struct packed {
    logic [6:0] next_width;
    logic [7:0] temperature;
    logic       servo_level;
  } result_t;

endpackage

// ----- rtl/core/tspg_div.sv -----
// ----------------------------------------------------------------------------
// tspg_div
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per divide.
// ----------------------------------------------------------------------------
module tspg_div (
  input  logic               clk,
  input  logic               rst,
  input  tspg_pkg::div_req_t req,
  output tspg_pkg::div_rsp_t rsp
);
  import tspg_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [NUM_W-1:0] dvd;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;

  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Trial subtraction for the current quotient bit.
  always_comb begin
    rem_shift = {rem, dvd[NUM_W-1]};
    diff      = rem_shift - {1'b0, den};
    fits      = rem_shift >= {1'b0, den};
  end

  // Control: busy while the quotient bits are collected, done pulses once at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend in, keep remainder, collect quotient bits.
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvd <= req.numer;
      den <= req.denom;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[NUM_W-2:0], 1'b0};
      rem <= fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

// ----- rtl/core/tspg_seq.sv -----
// ----------------------------------------------------------------------------
// tspg_seq
// Item sequencer: converts samples, classifies them against the bounds,
// drives the shared divider and keeps the servo pulse state.
// ----------------------------------------------------------------------------
module tspg_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [9:0]         in_sample,
  input  logic [7:0]         tmin_temp,
  input  logic [7:0]         tmax_temp,
  output tspg_pkg::div_req_t div_req,
  input  tspg_pkg::div_rsp_t div_rsp,
  output logic               res_push,
  input  logic               res_free,
  output tspg_pkg::result_t  res
);
  import tspg_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_CLASS = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int unsigned PROD_W = ADC_BITS + 8;

  logic [2:0]  state;
  logic [1:0]  op;
  logic [9:0]  sample;

  logic        pulse_active;
  logic [6:0]  tick_countdown;
  logic [6:0]  width_ticks;
  logic [7:0]  last_temperature;

  logic [PROD_W-1:0] prod;
  logic [7:0]  temp_ofs;
  logic [6:0]  count_dec;
  logic        above_max;
  logic        below_min;
  logic        in_band;

  // Sample scaling and band checks.
  always_comb begin
    prod      = PROD_W'(sample) * PROD_W'(ADC_SCALE);
    temp_ofs  = last_temperature - tmin_temp;
    count_dec = tick_countdown - 7'd1;
    above_max = last_temperature > tmax_temp;
    below_min = last_temperature < tmin_temp;
    in_band   = (last_temperature > tmin_temp) && (last_temperature < tmax_temp);
  end

  // Divider request: (temp - tmin) * 50 / (tmax - tmin).
  always_comb begin
    div_req.start = (state == ST_CLASS) && in_band && !above_max && !below_min;
    div_req.numer = NUM_W'(temp_ofs) * NUM_W'(WIDTH_SPAN);
    div_req.denom = tmax_temp - tmin_temp;
  end

  assign in_ready = (state == ST_IDLE);
  assign res_push = (state == ST_DONE) && res_free;

  assign res.servo_level = pulse_active;
  assign res.temperature = last_temperature;
  assign res.next_width  = width_ticks;

  // Sequencer and servo state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      pulse_active     <= 1'b1;
      tick_countdown   <= WIDTH_MAX;
      width_ticks      <= WIDTH_MAX;
      last_temperature <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (op)
            OP_SAMPLE: begin
              last_temperature <= prod[PROD_W-1:ADC_BITS];
              state            <= ST_CLASS;
            end
            OP_PERIOD: begin
              pulse_active <= 1'b1;
              state        <= ST_DONE;
            end
            OP_TICK: begin
              state <= ST_DONE;
              if (pulse_active) begin
                if (count_dec == 7'd0) begin
                  pulse_active   <= 1'b0;
                  tick_countdown <= width_ticks;
                end else begin
                  tick_countdown <= count_dec;
                end
              end
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_CLASS: begin
          // The upper clamp wins when the bounds are crossed.
          if (above_max) begin
            width_ticks <= WIDTH_MAX;
            state       <= ST_DONE;
          end else if (below_min) begin
            width_ticks <= WIDTH_MIN;
            state       <= ST_DONE;
          end else if (in_band) begin
            state <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            width_ticks <= WIDTH_MIN + {1'b0, div_rsp.quot[5:0]};
            state       <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op     <= in_op;
      sample <= in_sample;
    end
  end

endmodule

// ----- rtl/core/temperature_servo_pulse_generator_unit.sv -----
// ----------------------------------------------------------------------------
// temperature_servo_pulse_generator_unit
// Servo pulse generator whose pulse width follows a temperature reading.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one item per handshake: tuser holds the kind
//   (ADC sample, period start or width tick) and tdata the 10-bit sample.
//   Every accepted item yields exactly one result item on the output stream
//   with the pin level, the last temperature and the width for the next
//   reload.
//   A period start, tick or ignored item goes from the execute state to the
//   done state, and a sample outside the open band between the bounds
//   passes through the classify state first. A sample strictly between the
//   bounds also runs the shared restoring divider, one quotient bit per
//   cycle. The input is ready again in the cycle after the result is handed
//   on; one item is in work at a time.
//   The output register lets the next item be accepted while a result waits;
//   a stalled receiver holds the following result in the sequencer and the
//   input stays not ready until the output register frees.
//   The APB port sets tmin_temp (address 0) and tmax_temp (address 4); write
//   them only while the block is idle.
//   Synchronous reset: pin high, countdown and width 97, temperature 0,
//   bounds 0 and 150, no result pending.
// ----------------------------------------------------------------------------
module temperature_servo_pulse_generator_unit (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] adc_sample, [15:10] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] servo_level, [8:1] temperature,
                                      // [15:9] next_width
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tspg_pkg::*;

  logic [7:0] tmin_temp;
  logic [7:0] tmax_temp;

  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  res;
  logic     res_push;
  logic     res_free;

  logic     out_valid;
  result_t  out_data;

  // Bound registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tmin_temp <= TMIN_RESET;
      tmax_temp <= TMAX_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_TMIN: tmin_temp <= pwdata[7:0];
        REG_TMAX: tmax_temp <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TMIN: prdata = {24'd0, tmin_temp};
      REG_TMAX: prdata = {24'd0, tmax_temp};
      default:  prdata = '0;
    endcase
  end

  // Sequencer and shared divider.
  tspg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_sample (s_axis_tdata[9:0]),
    .tmin_temp (tmin_temp),
    .tmax_temp (tmax_temp),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_push  (res_push),
    .res_free  (res_free),
    .res       (res)
  );

  tspg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register.
  assign res_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_push;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_data.next_width, out_data.temperature, out_data.servo_level};

  // The sequencer works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // Every reported width stays within the clamp limits.
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:9] >= WIDTH_MIN) && (m_axis_tdata[15:9] <= WIDTH_MAX))
    else $error("reported width outside limits");

  // A divide never starts while the divider is still running.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // The divider finishes with a single done pulse.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |=> !div_rsp.done)
    else $error("divider done held longer than one cycle");

endmodule
